>>> design/i2p_pkg.sv
package i2p_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;

    // Precedence code: 0 stands for rank -1, so that ordering is kept unsigned.
    localparam logic [1:0] RANK_NONE = 2'd0;
    localparam logic [1:0] RANK_ADD  = 2'd1;
    localparam logic [1:0] RANK_MUL  = 2'd2;

    typedef struct packed {
        logic       valid;
        logic [7:0] out_char;
        logic       last;
        logic       end_of_expr;
        logic       overflow;
    } emit_t;

    function automatic logic [1:0] rank_code(input logic [7:0] ch);
        logic [1:0] r;
        r = RANK_NONE;
        if (ch == CH_PLUS || ch == CH_MINUS)
        begin
            r = RANK_ADD;
        end
        else if (ch == CH_STAR || ch == CH_SLASH || ch == CH_PCT)
        begin
            r = RANK_MUL;
        end
        return r;
    endfunction

    function automatic logic passes_through(input logic [7:0] ch);
        return ((ch >= CH_ZERO) && (ch <= CH_NINE)) || ((ch >= CH_LOW_A) && (ch <= CH_LOW_Z));
    endfunction

endpackage

>>> design/i2p_if.sv
interface i2p_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] symbol;

    modport source (output valid, output req_type, output symbol, input ready);
    modport sink   (input valid, input req_type, input symbol, output ready);
endinterface

interface i2p_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last;
    logic       end_of_expr;
    logic       overflow;

    modport source (output valid, output out_char, output last, output end_of_expr,
                    output overflow, input ready);
    modport sink   (input valid, input out_char, input last, input end_of_expr,
                    input overflow, output ready);
endinterface

>>> design/i2p_ram.sv
module i2p_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/i2p_ctrl.sv
module i2p_ctrl
    import i2p_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    i2p_in_if.sink            infix,
    input  logic              can_emit,
    output emit_t             emit,
    output logic [CNT_W-1:0]  depth,
    output logic              ram_we,
    output logic [ADDR_W-1:0] ram_waddr,
    output logic [7:0]        ram_wdata,
    output logic              ram_re,
    output logic [ADDR_W-1:0] ram_raddr,
    input  logic [7:0]        ram_rdata
);

    typedef enum logic [1:0] {S_IDLE, S_EVAL, S_LOAD} state_t;

    state_t           state_reg, state_next;
    logic             req_reg, req_next;
    logic [7:0]       sym_reg, sym_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       top_reg, top_next;
    logic [7:0]       sec_reg, sec_next;
    logic             ovf_reg, ovf_next;
    logic             idle_after_reg, idle_after_next;

    logic             do_pop;
    logic             pop_done;
    logic             do_push;
    logic [CNT_W-1:0] cnt_m3;
    logic [1:0]       sym_rank;

    assign cnt_m3    = count_reg - CNT_W'(3);
    assign sym_rank  = rank_code(sym_reg);
    assign depth     = count_reg;
    assign infix.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        sym_next        = sym_reg;
        count_next      = count_reg;
        top_next        = top_reg;
        sec_next        = sec_reg;
        ovf_next        = ovf_reg;
        idle_after_next = idle_after_reg;
        emit            = '0;
        do_pop          = 1'b0;
        pop_done        = 1'b0;
        do_push         = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = count_reg[ADDR_W-1:0];
        ram_wdata       = sym_reg;
        ram_re          = 1'b0;
        ram_raddr       = cnt_m3[ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (infix.valid)
                begin
                    req_next   = infix.req_type;
                    sym_next   = infix.symbol;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (req_reg)
                begin
                    if (count_reg != '0)
                    begin
                        if (can_emit)
                        begin
                            emit.valid    = 1'b1;
                            emit.out_char = top_reg;
                            do_pop        = 1'b1;
                        end
                    end
                    else if (can_emit)
                    begin
                        emit.valid       = 1'b1;
                        emit.last        = 1'b1;
                        emit.end_of_expr = 1'b1;
                        emit.overflow    = ovf_reg;
                        count_next       = '0;
                        ovf_next         = 1'b0;
                        state_next       = S_IDLE;
                    end
                end
                else if (passes_through(sym_reg))
                begin
                    if (can_emit)
                    begin
                        emit.valid    = 1'b1;
                        emit.out_char = sym_reg;
                        emit.last     = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else if (sym_reg == CH_LPAREN)
                begin
                    do_push = 1'b1;
                end
                else if (sym_reg == CH_RPAREN)
                begin
                    if (count_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (top_reg == CH_LPAREN)
                    begin
                        // The matching bracket is dropped without a word.
                        do_pop   = 1'b1;
                        pop_done = 1'b1;
                    end
                    else if (can_emit)
                    begin
                        emit.valid    = 1'b1;
                        emit.out_char = top_reg;
                        emit.last     = (count_reg == CNT_W'(1)) || (sec_reg == CH_LPAREN);
                        do_pop        = 1'b1;
                        pop_done      = (count_reg == CNT_W'(1));
                    end
                end
                else if ((count_reg != '0) && (rank_code(top_reg) >= sym_rank))
                begin
                    if (can_emit)
                    begin
                        emit.valid    = 1'b1;
                        emit.out_char = top_reg;
                        emit.last     = (count_reg == CNT_W'(1)) || (rank_code(sec_reg) < sym_rank);
                        do_pop        = 1'b1;
                    end
                end
                else
                begin
                    do_push = 1'b1;
                end
            end
            S_LOAD:
            begin
                sec_next   = ram_rdata;
                state_next = idle_after_reg ? S_IDLE : S_EVAL;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // The two top entries live in registers; a pop refills the second
        // from memory, through the S_LOAD state, when entries remain below.
        if (do_pop)
        begin
            top_next   = sec_reg;
            count_next = count_reg - CNT_W'(1);
            if (count_reg >= CNT_W'(3))
            begin
                ram_re          = 1'b1;
                idle_after_next = pop_done;
                state_next      = S_LOAD;
            end
            else
            begin
                state_next = pop_done ? S_IDLE : S_EVAL;
            end
        end

        if (do_push)
        begin
            state_next = S_IDLE;
            if (count_reg >= CNT_W'(STACK_DEPTH))
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                ram_we     = 1'b1;
                sec_next   = top_reg;
                top_next   = sym_reg;
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            idle_after_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            idle_after_reg <= idle_after_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        sym_reg <= sym_next;
        top_reg <= top_next;
        sec_reg <= sec_next;
    end

endmodule

>>> design/infix_to_postfix_converter.sv
// Channel   Modport   Word
// infix     sink      req_type (1), symbol (8)
// postfix   source    out_char (8), last (1), end_of_expr (1), overflow (1)
//
// An item is taken in S_IDLE and decided in S_EVAL. Each popped operator
// takes another pass through S_EVAL, and one through S_LOAD when entries
// remain below the two cached in registers, because the stack memory has a
// registered read. Reset leaves the stack empty and ready at once. The output
// register lets the next item be taken while a word waits; a stalled postfix
// channel holds the block only when it has a word to emit.
module infix_to_postfix_converter
    import i2p_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    i2p_in_if.sink     infix,
    i2p_out_if.source  postfix
);

    emit_t             emit;
    logic              can_emit;
    logic [CNT_W-1:0]  depth;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    logic              out_valid_reg;
    logic [7:0]        out_char_reg;
    logic              last_reg;
    logic              eoe_reg;
    logic              ovf_reg;

    assign can_emit = !out_valid_reg || postfix.ready;

    i2p_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .infix     (infix),
        .can_emit  (can_emit),
        .emit      (emit),
        .depth     (depth),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    i2p_ram #(
        .WIDTH (8),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (postfix.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            out_char_reg <= emit.out_char;
            last_reg     <= emit.last;
            eoe_reg      <= emit.end_of_expr;
            ovf_reg      <= emit.overflow;
        end
    end

    assign postfix.valid       = out_valid_reg;
    assign postfix.out_char    = out_char_reg;
    assign postfix.last        = last_reg;
    assign postfix.end_of_expr = eoe_reg;
    assign postfix.overflow    = ovf_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit.valid |-> can_emit)
        else $error("word emitted while the output register still holds one");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond its depth");

    a_clear_after_term: assert property (@(posedge clk) disable iff (!rst_n)
        (emit.valid && emit.end_of_expr) |=> (depth == '0))
        else $error("stack not empty after terminator");

    a_term_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (emit.valid && emit.end_of_expr) |-> (emit.last && (emit.out_char == 8'h00)))
        else $error("terminator word malformed");

endmodule
